// ----- hdl/drntm_pkg.sv -----
// ----------------------------------------------------------------------------
// drntm_pkg
// Shared constants, register codes and types for the dR nearest truth match.
// ----------------------------------------------------------------------------
`default_nettype none

package drntm_pkg;

  // truth list length limit and its counter width
  localparam int MAX_TRUTH_ITEMS = 65536;
  localparam int CNT_W           = $clog2(MAX_TRUTH_ITEMS + 1);

  // accepted type code slots
  localparam int TYPE_SLOTS = 4;
  localparam int REG_SLOTS  = 4;
  localparam int USED_SLOTS = (TYPE_SLOTS < REG_SLOTS) ? TYPE_SLOTS : REG_SLOTS;

  // front to back queue, counting words still in the front pipeline too
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // stream widths
  localparam int IN_W  = 152;
  localparam int OUT_W = 48;

  // fixed point constants
  localparam logic signed [15:0] PI_FIX        = 16'sd12868;
  localparam logic signed [15:0] TWO_PI_FIX    = 16'sd25736;
  localparam logic [30:0]        DIST_LIMIT_SQ = 31'd1677721600;
  localparam logic [7:0]         STATUS_FINAL  = 8'd1;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_CHARGE_MATCH = 3'd0;
  localparam logic [2:0] REG_DR_CUT       = 3'd1;
  localparam logic [2:0] REG_DPT_CUT      = 3'd2;
  localparam logic [2:0] REG_TYPE_COUNT   = 3'd3;
  localparam logic [2:0] REG_TYPE_CODE_A  = 3'd4;
  localparam logic [2:0] REG_TYPE_CODE_B  = 3'd5;
  localparam logic [2:0] REG_TYPE_CODE_C  = 3'd6;
  localparam logic [2:0] REG_TYPE_CODE_D  = 3'd7;

  // register reset values
  localparam logic [15:0] DR_CUT_RST  = 16'd2048;
  localparam logic [13:0] DPT_CUT_RST = 14'd512;

  typedef struct packed {
    logic                          charge_match;
    logic [15:0]                   dr_cut;
    logic [13:0]                   dpt_cut;
    logic [2:0]                    type_count;
    logic [REG_SLOTS-1:0][23:0]    type_code;
  } drntm_cfg_t;

  typedef struct packed {
    logic        ok;       // passed every cut but the running minimum
    logic        last;
    logic [15:0] index;
    logic [31:0] dist_sq;  // squared distance, exact when ok
  } drntm_entry_t;

endpackage

`default_nettype wire

// ----- hdl/drntm_front.sv -----
// ----------------------------------------------------------------------------
// drntm_front
// Accepts truth words, applies preselection and computes distance / pt cuts.
// ----------------------------------------------------------------------------
`default_nettype none

module drntm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [drntm_pkg::IN_W-1:0]  in_tdata,
  input  logic                        in_tlast,
  input  drntm_pkg::drntm_cfg_t       cfg,
  input  logic                        q_pop,
  output logic                        q_push,
  output drntm_pkg::drntm_entry_t     q_wdata
);
  import drntm_pkg::*;

  logic signed [15:0] reco_eta, truth_eta;
  logic signed [14:0] reco_phi, truth_phi;
  logic        [15:0] reco_pt, truth_pt;
  logic signed [2:0]  reco_charge, truth_charge;
  logic        [7:0]  truth_status;
  logic        [23:0] truth_type;
  logic        [15:0] truth_index;

  logic               acc;
  logic signed [16:0] deta;
  logic signed [15:0] dphi_raw, dphi;
  logic        [15:0] ae, ap_full, dpt;
  logic               type_hit, pre_ok;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [QCNT_W-1:0] occ_r, occ_nxt;

  // stage A
  logic        va_r, a_pre_r, a_nz_r, a_last_r;
  logic [15:0] a_idx_r, a_ae_r, a_dpt_r, a_rpt_r;
  logic [13:0] a_ap_r;

  // stage B
  logic        vb_r, b_ok_r, b_last_r;
  logic [15:0] b_idx_r;
  logic [31:0] b_ae2_r;
  logic [27:0] b_ap2_r;
  logic [25:0] b_ptl_r;
  logic [29:0] b_ptr_r;

  logic [31:0] cut2_r;
  logic [32:0] d2;

  always_comb begin
    reco_eta     = $signed(in_tdata[15:0]);
    reco_phi     = $signed(in_tdata[30:16]);
    reco_pt      = in_tdata[46:31];
    reco_charge  = $signed(in_tdata[49:47]);
    truth_eta    = $signed(in_tdata[65:50]);
    truth_phi    = $signed(in_tdata[80:66]);
    truth_pt     = in_tdata[96:81];
    truth_charge = $signed(in_tdata[99:97]);
    truth_status = in_tdata[107:100];
    truth_type   = in_tdata[131:108];
    truth_index  = in_tdata[147:132];
  end

  assign in_tready = (occ_r < QCNT_W'(QDEPTH));
  assign acc       = in_tvalid && in_tready;

  // eta / phi differences, phi folded back by one turn at most
  always_comb begin
    deta     = {truth_eta[15], truth_eta} - {reco_eta[15], reco_eta};
    ae       = deta[16] ? 16'(-deta) : deta[15:0];
    dphi_raw = {truth_phi[14], truth_phi} - {reco_phi[14], reco_phi};
    if (dphi_raw > PI_FIX) begin
      dphi = dphi_raw - TWO_PI_FIX;
    end else if (dphi_raw < -PI_FIX) begin
      dphi = dphi_raw + TWO_PI_FIX;
    end else begin
      dphi = dphi_raw;
    end
    ap_full = dphi[15] ? 16'(-dphi) : dphi;
    dpt     = (reco_pt > truth_pt) ? (reco_pt - truth_pt) : (truth_pt - reco_pt);
  end

  always_comb begin
    type_hit = (cfg.type_count == 3'd0);
    for (int i = 0; i < USED_SLOTS; i++) begin
      if ((3'(i) < cfg.type_count) && (cfg.type_code[i] == truth_type)) begin
        type_hit = 1'b1;
      end
    end
    pre_ok = (cnt_r < CNT_W'(MAX_TRUTH_ITEMS)) && (truth_status == STATUS_FINAL) &&
             type_hit && (!cfg.charge_match || (truth_charge == reco_charge));
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc) begin
      if (in_tlast) begin
        cnt_nxt = '0;
      end else if (cnt_r < CNT_W'(MAX_TRUTH_ITEMS)) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    case ({acc, q_pop})
      2'b10:   occ_nxt = occ_r + QCNT_W'(1);
      2'b01:   occ_nxt = occ_r - QCNT_W'(1);
      default: occ_nxt = occ_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      occ_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      occ_r <= occ_nxt;
      va_r  <= acc;
      vb_r  <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    cut2_r   <= cfg.dr_cut * cfg.dr_cut;
    a_pre_r  <= pre_ok;
    a_nz_r   <= (reco_pt != 16'd0);
    a_last_r <= in_tlast;
    a_idx_r  <= truth_index;
    a_ae_r   <= ae;
    a_ap_r   <= ap_full[13:0];
    a_dpt_r  <= dpt;
    a_rpt_r  <= reco_pt;
    b_ok_r   <= a_pre_r && a_nz_r;
    b_last_r <= a_last_r;
    b_idx_r  <= a_idx_r;
    b_ae2_r  <= a_ae_r * a_ae_r;
    b_ap2_r  <= a_ap_r * a_ap_r;
    b_ptl_r  <= {a_dpt_r, 10'd0};
    b_ptr_r  <= cfg.dpt_cut * a_rpt_r;
  end

  assign d2 = {1'b0, b_ae2_r} + {5'd0, b_ap2_r};

  always_comb begin
    q_push          = vb_r;
    q_wdata.ok      = b_ok_r && (d2 <= {1'b0, cut2_r}) && ({4'd0, b_ptl_r} <= b_ptr_r);
    q_wdata.last    = b_last_r;
    q_wdata.index   = b_idx_r;
    q_wdata.dist_sq = d2[31:0];
  end

endmodule

`default_nettype wire

// ----- hdl/drntm_queue.sv -----
// ----------------------------------------------------------------------------
// drntm_queue
// Short FIFO between the classifying front and the running-minimum back.
// ----------------------------------------------------------------------------
`default_nettype none

module drntm_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  drntm_pkg::drntm_entry_t wdata,
  input  logic                    pop,
  output drntm_pkg::drntm_entry_t rdata,
  output logic                    empty
);
  import drntm_pkg::*;

  drntm_entry_t      mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/drntm_back.sv -----
// ----------------------------------------------------------------------------
// drntm_back
// Keeps the nearest passing candidate and presents the result per list.
// ----------------------------------------------------------------------------
`default_nettype none

module drntm_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  drntm_pkg::drntm_entry_t      head,
  input  logic                         empty,
  output logic                         pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [drntm_pkg::OUT_W-1:0]  out_tdata
);
  import drntm_pkg::*;

  logic [30:0] best_dist_r, best_dist_nxt;
  logic [15:0] best_idx_r, best_idx_nxt;
  logic        have_r, have_nxt;
  logic        out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic        upd;
  logic [30:0] cur_dist;
  logic [15:0] cur_idx;
  logic        cur_have;

  // a last word waits while the output register still holds a result
  assign pop = !empty && (!head.last || !out_valid_r || out_tready);

  always_comb begin
    upd      = head.ok && (head.dist_sq < {1'b0, best_dist_r});
    cur_have = have_r || upd;
    cur_idx  = upd ? head.index : best_idx_r;
    cur_dist = upd ? head.dist_sq[30:0] : best_dist_r;
    best_dist_nxt = best_dist_r;
    best_idx_nxt  = best_idx_r;
    have_nxt      = have_r;
    if (pop) begin
      if (head.last) begin
        best_dist_nxt = DIST_LIMIT_SQ;
        best_idx_nxt  = 16'd0;
        have_nxt      = 1'b0;
      end else begin
        best_dist_nxt = cur_dist;
        best_idx_nxt  = cur_idx;
        have_nxt      = cur_have;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dist_r <= DIST_LIMIT_SQ;
      best_idx_r  <= 16'd0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      best_dist_r <= best_dist_nxt;
      best_idx_r  <= best_idx_nxt;
      have_r      <= have_nxt;
      if (pop && head.last) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_data_r <= cur_have ? {cur_dist, cur_idx, 1'b1} : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ----- hdl/delta_r_nearest_truth_match_top.sv -----
// ----------------------------------------------------------------------------
// delta_r_nearest_truth_match_top
// Matches one reconstructed particle against a stream of truth candidates.
// ----------------------------------------------------------------------------
// Each input word carries the reconstructed particle and one truth candidate;
// in_tlast marks the final candidate of the list. The block takes one word per
// clock while in_tready is high. A candidate counts when its status is 1, its
// type code is among the first type_count codes (type_count 0 takes any code),
// its charge matches when charge_match is set, its squared eta-phi distance
// (phi wrapped by one turn) is within dr_cut squared and |reco_pt - truth_pt|
// * 1024 is within dpt_cut * reco_pt (zero reco pt passes nothing). The
// strictly nearest such candidate below ten units is kept, the first one
// winning a tie. On the last word one result word leaves: found, best index,
// squared distance (index and distance zero when nothing matched). Stage A
// (preselect) and stage B (multiply) are registered; the cut compare feeds
// the queue. Up to eight words may be in flight between the front and the
// running-minimum back end; with a result held by out_tready low, input flows
// until a last word waits and those eight are used. Registers sit at byte
// address 4 * index, to be written only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_r_nearest_truth_match_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // reco_eta, reco_phi, reco_pt, reco_charge, truth_eta, truth_phi,
  // truth_pt, truth_charge, truth_status, truth_type, truth_index, 4 pad bits
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [drntm_pkg::IN_W-1:0]  in_tdata,
  input  logic                        in_tlast,
  // found, best_index, best_distance_sq
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [drntm_pkg::OUT_W-1:0] out_tdata,
  // register port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [4:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import drntm_pkg::*;

  logic        charge_match_r;
  logic [15:0] dr_cut_r;
  logic [13:0] dpt_cut_r;
  logic [2:0]  type_count_r;
  logic [REG_SLOTS-1:0][23:0] type_code_r;

  logic         wr_en;
  logic [2:0]   reg_idx;
  drntm_cfg_t   cfg;
  drntm_entry_t q_wdata, q_head;
  logic         q_push, q_pop, q_empty;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charge_match_r <= 1'b0;
      dr_cut_r       <= DR_CUT_RST;
      dpt_cut_r      <= DPT_CUT_RST;
      type_count_r   <= 3'd0;
      type_code_r    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CHARGE_MATCH: charge_match_r <= cfg_pwdata[0];
        REG_DR_CUT:       dr_cut_r       <= cfg_pwdata[15:0];
        REG_DPT_CUT:      dpt_cut_r      <= cfg_pwdata[13:0];
        REG_TYPE_COUNT:   type_count_r   <= cfg_pwdata[2:0];
        REG_TYPE_CODE_A:  type_code_r[0] <= cfg_pwdata[23:0];
        REG_TYPE_CODE_B:  type_code_r[1] <= cfg_pwdata[23:0];
        REG_TYPE_CODE_C:  type_code_r[2] <= cfg_pwdata[23:0];
        REG_TYPE_CODE_D:  type_code_r[3] <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    case (reg_idx)
      REG_CHARGE_MATCH: cfg_prdata = {31'd0, charge_match_r};
      REG_DR_CUT:       cfg_prdata = {16'd0, dr_cut_r};
      REG_DPT_CUT:      cfg_prdata = {18'd0, dpt_cut_r};
      REG_TYPE_COUNT:   cfg_prdata = {29'd0, type_count_r};
      REG_TYPE_CODE_A:  cfg_prdata = {8'd0, type_code_r[0]};
      REG_TYPE_CODE_B:  cfg_prdata = {8'd0, type_code_r[1]};
      REG_TYPE_CODE_C:  cfg_prdata = {8'd0, type_code_r[2]};
      REG_TYPE_CODE_D:  cfg_prdata = {8'd0, type_code_r[3]};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.charge_match = charge_match_r;
    cfg.dr_cut       = dr_cut_r;
    cfg.dpt_cut      = dpt_cut_r;
    cfg.type_count   = type_count_r;
    cfg.type_code    = type_code_r;
  end

  // front: accept, preselect, multiply, cut compare
  drntm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg       (cfg),
    .q_pop     (q_pop),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  drntm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  // back: running minimum and result register
  drntm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ----- hdl/drntm_checker.sv -----
// ----------------------------------------------------------------------------
// drntm_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module drntm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [drntm_pkg::OUT_W-1:0] out_tdata
);
  import drntm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> (out_tdata[OUT_W-1:1] == '0))
    else $error("no-match result carries index or distance");

  a_match_near: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> (out_tdata[47:17] < DIST_LIMIT_SQ))
    else $error("match distance not below ten units");

endmodule

bind delta_r_nearest_truth_match_top drntm_checker u_drntm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
